// File: rtl/rca_pkg.sv
// rca_pkg: sizes, codes and shared types of the register cache allocator
// no dependencies; imported by every module under rtl
`default_nettype none

package rca_pkg;

    // table sizes
    localparam int NUM_VIRT = 16;
    localparam int NUM_PHYS = 10;

    // field widths
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;
    localparam int REG_W  = 4;

    // derived index widths
    localparam int VIDX_W = (NUM_VIRT > 1) ? $clog2(NUM_VIRT) : 1;
    localparam int PIDX_W = (NUM_PHYS > 1) ? $clog2(NUM_PHYS) : 1;
    localparam int WB_W   = $clog2(NUM_PHYS + 1);

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_STORE   = 3'd1;
    localparam logic [OP_W-1:0] OP_LDST    = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] K_GRANT  = 3'd0;
    localparam logic [KIND_W-1:0] K_WB     = 3'd1;
    localparam logic [KIND_W-1:0] K_FILL   = 3'd2;
    localparam logic [KIND_W-1:0] K_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] K_BADREG = 3'd4;
    localparam logic [KIND_W-1:0] K_NOFREE = 3'd5;

    // physical register marks (code 3 never arises and counts as in use)
    localparam logic [1:0] MARK_FREE   = 2'd0;
    localparam logic [1:0] MARK_MAPPED = 2'd1;
    localparam logic [1:0] MARK_INUSE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FILL,
        ST_GRANT,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // one virtual map entry
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [REG_W-1:0] phys;
    } t_vmap;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_TAKE,
        MK_RELEASE,
        MK_CLEAR
    } t_mark_op;

    typedef struct packed {
        t_mark_op         op;
        logic [REG_W-1:0] idx;
    } t_mark_cmd;

    typedef struct packed {
        logic              free_ok;
        logic [PIDX_W-1:0] free_idx;
        logic              map_ok;
        logic [PIDX_W-1:0] map_idx;
    } t_mark_find;

    // shared compare unit result
    typedef struct packed {
        logic              hit;
        logic              wb;
        logic              at_end;
        logic [VIDX_W-1:0] idx_next;
    } t_match;

endpackage

`default_nettype wire

// File: rtl/register_cache_allocator.sv
// register_cache_allocator: top level, sequencer, virtual map and result register
// depends on rca_pkg, rca_match, rca_marks
`default_nettype none

// Write-back cache of NUM_VIRT - 1 virtual registers over NUM_PHYS physical
// registers. A command word is taken at a clock edge with start high and
// busy low; results come out on o_kind/o_phys_reg/o_slot_reg, each marked
// by o_valid for exactly one cycle, with o_last on the final
// result of the command. The receiver cannot stall: every strobed word must
// be captured in the cycle it appears. A miss that evicts scans the virtual
// map for the owner of the victim (up to NUM_VIRT entries); a flush of a
// non-empty table walks every entry. Both walk the virtual map one entry
// per cycle through a single shared compare unit.
module register_cache_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rca_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [rca_pkg::REG_W-1:0]     i_virt_reg,
    output logic                               o_valid,
    output logic [rca_pkg::KIND_W-1:0]         o_kind,
    output logic [rca_pkg::REG_W-1:0]          o_phys_reg,
    output logic [rca_pkg::REG_W-1:0]          o_slot_reg,
    output logic                               o_last
);
    import rca_pkg::*;

    // sequencer and operand registers
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [REG_W-1:0]    r_vreg, n_vreg;
    logic [VIDX_W-1:0]   r_vidx, n_vidx;
    logic [PIDX_W-1:0]   r_phys, n_phys;
    logic [WB_W-1:0]     r_wbcnt, n_wbcnt;
    logic                r_any, n_any;

    // virtual map, one read address (r_vidx), one write port
    t_vmap               r_vmap [NUM_VIRT];
    t_vmap               w_rd;
    logic                map_we;
    logic [VIDX_W-1:0]   map_addr;
    t_vmap               map_wdata;

    // result word register
    logic                r_valid, r_last;
    logic [KIND_W-1:0]   r_kind;
    logic [REG_W-1:0]    r_phys_out, r_slot_out;
    logic                emit, e_last;
    logic [KIND_W-1:0]   e_kind;
    logic [REG_W-1:0]    e_phys, e_slot;

    t_mark_cmd           mcmd;
    t_mark_find          find;
    t_match              w_m;
    logic                bad_reg;
    logic                is_access;

    assign w_rd      = r_vmap[r_vidx];
    assign bad_reg   = (r_vreg >= REG_W'(NUM_VIRT - 1));
    assign is_access = (r_op inside {OP_LOAD, OP_STORE, OP_LDST});
    assign busy      = (r_state != ST_IDLE);

    rca_match u_match (
        .i_entry  (w_rd),
        .i_target (REG_W'(r_phys)),
        .i_idx    (r_vidx),
        .o_res    (w_m)
    );

    rca_marks u_marks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mcmd),
        .o_find  (find)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                if (is_access && !bad_reg && !w_rd.valid) begin
                    if (find.free_ok) begin
                        n_state = ST_FILL;
                    end else if (find.map_ok) begin
                        n_state = ST_SCAN;
                    end
                end else if ((r_op == OP_FLUSH) && r_any) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SCAN: begin
                if (w_m.hit || w_m.at_end) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL:  n_state = ST_GRANT;
            ST_GRANT: n_state = ST_IDLE;
            ST_FLUSH: begin
                if (w_m.at_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs, table writes and operand updates
    always_comb begin
        emit      = 1'b0;
        e_last    = 1'b0;
        e_kind    = K_DONE;
        e_phys    = '0;
        e_slot    = '0;
        map_we    = 1'b0;
        map_addr  = r_vidx;
        map_wdata = '0;
        mcmd      = '{op: MK_NONE, idx: '0};
        n_op      = r_op;
        n_vreg    = r_vreg;
        n_vidx    = r_vidx;
        n_phys    = r_phys;
        n_wbcnt   = r_wbcnt;
        n_any     = r_any;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_vreg  = i_virt_reg;
                    n_vidx  = i_virt_reg[VIDX_W-1:0];
                    n_wbcnt = '0;
                end
            end
            ST_DECODE: begin
                if (is_access) begin
                    if (bad_reg) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_kind = K_BADREG;
                    end else if (w_rd.valid) begin
                        // hit: mark in use, stores dirty the entry
                        mcmd = '{op: MK_TAKE, idx: w_rd.phys};
                        if (r_op != OP_LOAD) begin
                            map_we          = 1'b1;
                            map_wdata       = w_rd;
                            map_wdata.dirty = 1'b1;
                        end
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_kind = K_GRANT;
                        e_phys = w_rd.phys;
                        e_slot = r_vreg;
                    end else if (find.free_ok) begin
                        n_phys = find.free_idx;
                        mcmd   = '{op: MK_TAKE, idx: REG_W'(find.free_idx)};
                        n_any  = 1'b1;
                    end else if (find.map_ok) begin
                        // evict: walk the map for the victim's owner
                        n_phys = find.map_idx;
                        n_vidx = '0;
                    end else begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_kind = K_NOFREE;
                    end
                end else if (r_op == OP_FLUSH) begin
                    if (r_any) begin
                        n_vidx = '0;
                    end else begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_kind = K_DONE;
                    end
                end else if (r_op == OP_RELEASE) begin
                    mcmd   = '{op: MK_RELEASE, idx: '0};
                    emit   = 1'b1;
                    e_last = 1'b1;
                    e_kind = K_DONE;
                end else begin
                    // undefined opcode
                    emit   = 1'b1;
                    e_last = 1'b1;
                    e_kind = K_DONE;
                end
            end
            ST_SCAN: begin
                if (w_m.hit) begin
                    if (w_m.wb) begin
                        emit   = 1'b1;
                        e_kind = K_WB;
                        e_phys = REG_W'(r_phys);
                        e_slot = REG_W'(r_vidx);
                    end
                    map_we = 1'b1;
                end
                if (w_m.hit || w_m.at_end) begin
                    // owner gone (or none found): victim is now ours
                    mcmd  = '{op: MK_TAKE, idx: REG_W'(r_phys)};
                    n_any = 1'b1;
                end else begin
                    n_vidx = w_m.idx_next;
                end
            end
            ST_FILL: begin
                if (r_op != OP_STORE) begin
                    emit   = 1'b1;
                    e_kind = K_FILL;
                    e_phys = REG_W'(r_phys);
                    e_slot = r_vreg;
                end
            end
            ST_GRANT: begin
                map_we          = 1'b1;
                map_addr        = r_vreg[VIDX_W-1:0];
                map_wdata.valid = 1'b1;
                map_wdata.dirty = (r_op != OP_LOAD);
                map_wdata.phys  = REG_W'(r_phys);
                emit            = 1'b1;
                e_last          = 1'b1;
                e_kind          = K_GRANT;
                e_phys          = REG_W'(r_phys);
                e_slot          = r_vreg;
            end
            ST_FLUSH: begin
                // writebacks capped at NUM_PHYS words
                if (w_m.wb && (r_wbcnt < WB_W'(NUM_PHYS))) begin
                    emit    = 1'b1;
                    e_kind  = K_WB;
                    e_phys  = w_rd.phys;
                    e_slot  = REG_W'(r_vidx);
                    n_wbcnt = r_wbcnt + WB_W'(1);
                end
                map_we = 1'b1;
                if (w_m.at_end) begin
                    mcmd  = '{op: MK_CLEAR, idx: '0};
                    n_any = 1'b0;
                end else begin
                    n_vidx = w_m.idx_next;
                end
            end
            ST_DONE: begin
                emit   = 1'b1;
                e_last = 1'b1;
                e_kind = K_DONE;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_any   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_any   <= n_any;
            r_valid <= emit;
        end
    end

    // operand and result payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_vreg     <= n_vreg;
        r_vidx     <= n_vidx;
        r_phys     <= n_phys;
        r_wbcnt    <= n_wbcnt;
        r_kind     <= e_kind;
        r_phys_out <= e_phys;
        r_slot_out <= e_slot;
        r_last     <= e_last;
    end

    // virtual map, cleared to unmapped by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VIRT; v++) begin
                r_vmap[v] <= '0;
            end
        end else if (map_we) begin
            r_vmap[map_addr] <= map_wdata;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_phys_reg = r_phys_out;
    assign o_slot_reg = r_slot_out;
    assign o_last     = r_last;

    // a grant always names an existing physical register
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_GRANT)) |-> ({1'b0, o_phys_reg} < 5'(NUM_PHYS)))
        else $error("grant of nonexistent physical register");

    // single-word answers always close the command
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == K_DONE) || (o_kind == K_BADREG) || (o_kind == K_NOFREE)))
        |-> o_last)
        else $error("done or error word without last");

    // a gap cycle always follows the last word of a command
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("word right after last");

    // an accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

endmodule

`default_nettype wire

// File: rtl/rca_match.sv
// rca_match: shared compare unit used by every scan of the virtual map
// depends on rca_pkg
`default_nettype none

module rca_match (
    input  wire rca_pkg::t_vmap                   i_entry,
    input  wire logic [rca_pkg::REG_W-1:0]        i_target,
    input  wire logic [rca_pkg::VIDX_W-1:0]       i_idx,
    output rca_pkg::t_match                       o_res
);
    import rca_pkg::*;

    // owner of the target, dirty valid entry, scan position
    assign o_res.hit      = i_entry.valid && (i_entry.phys == i_target);
    assign o_res.wb       = i_entry.valid && i_entry.dirty;
    assign o_res.at_end   = (i_idx == VIDX_W'(NUM_VIRT - 1));
    assign o_res.idx_next = i_idx + VIDX_W'(1);

endmodule

`default_nettype wire

// File: rtl/rca_marks.sv
// rca_marks: physical register mark file with lowest-free / lowest-mapped search
// depends on rca_pkg
`default_nettype none

module rca_marks (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rca_pkg::t_mark_cmd    i_cmd,
    output rca_pkg::t_mark_find        o_find
);
    import rca_pkg::*;

    logic [1:0] r_marks [NUM_PHYS];
    logic [1:0] n_marks [NUM_PHYS];

    always_comb begin
        o_find = '0;
        for (int p = NUM_PHYS - 1; p >= 0; p--) begin
            if (r_marks[p] == MARK_FREE) begin
                o_find.free_ok  = 1'b1;
                o_find.free_idx = PIDX_W'(p);
            end
            if (r_marks[p] == MARK_MAPPED) begin
                o_find.map_ok  = 1'b1;
                o_find.map_idx = PIDX_W'(p);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PHYS; p++) begin
            n_marks[p] = r_marks[p];
            case (i_cmd.op)
                MK_TAKE: begin
                    if ((i_cmd.idx == REG_W'(p)) && ({1'b0, i_cmd.idx} < 5'(NUM_PHYS))) begin
                        n_marks[p] = MARK_INUSE;
                    end
                end
                MK_RELEASE: begin
                    if (r_marks[p] == MARK_INUSE) begin
                        n_marks[p] = MARK_MAPPED;
                    end
                end
                MK_CLEAR: n_marks[p] = MARK_FREE;
                default:  n_marks[p] = r_marks[p];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PHYS; p++) begin
            if (!i_rst_n) begin
                r_marks[p] <= MARK_FREE;
            end else begin
                r_marks[p] <= n_marks[p];
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_register_cache_allocator.sv
// tb_register_cache_allocator: self-checking bench for the register cache allocator
// depends on rtl/rca_pkg.sv and rtl/register_cache_allocator.sv; directed table then random words
`default_nettype none

module tb_register_cache_allocator;
    import rca_pkg::*;

    // opcodes the block leaves undefined, each answered with a single done
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    // virtual register that is always refused on load, store and load-store
    localparam logic [REG_W-1:0] VREG_REFUSED = REG_W'(NUM_VIRT - 1);

    localparam int RAND_ITEMS  = 460;
    localparam int BURST       = 20;
    localparam int DRAIN       = 2 * NUM_VIRT + 8;
    localparam int CYCLE_LIMIT = 200000;

    // one result word as it appears on the output ports
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  phys;
        logic [REG_W-1:0]  slot;
        logic              last;
    } t_word;

    localparam t_word NO_WORD = '0;

    // one line of the directed table; typed_cnt > 0 means the answer is written in
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [REG_W-1:0] vreg;
        int               typed_cnt;
        t_word            first;
        t_word            second;
    } t_step_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [REG_W-1:0]  i_virt_reg = '0;
    logic              busy;
    logic              o_valid;
    logic [KIND_W-1:0] o_kind;
    logic [REG_W-1:0]  o_phys_reg;
    logic [REG_W-1:0]  o_slot_reg;
    logic              o_last;

    // typed answer that travels along with the command on the bus
    int    typed_cnt = 0;
    t_word typed_first = '0;
    t_word typed_second = '0;

    // shadow copy of the allocator state
    t_vmap      virt_entry [NUM_VIRT];
    logic [1:0] phys_mark [NUM_PHYS];
    bit         table_live;

    t_word     cmd_words[$];      // words produced by the command just taken
    t_word     awaited_words[$];  // words still owed by the block, oldest first
    t_step_row script[$];
    int        fail_count = 0;
    int        cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    register_cache_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_virt_reg (i_virt_reg),
        .o_valid    (o_valid),
        .o_kind     (o_kind),
        .o_phys_reg (o_phys_reg),
        .o_slot_reg (o_slot_reg),
        .o_last     (o_last)
    );

    function automatic t_word mk(input logic [KIND_W-1:0] kind, input int phys, input int slot);
        t_word r;
        r.kind = kind;
        r.phys = REG_W'(phys);
        r.slot = REG_W'(slot);
        r.last = 1'b0;
        return r;
    endfunction

    // walks the shadow state for one command and leaves its words in cmd_words
    task automatic predict_command(input logic [OP_W-1:0] op, input logic [REG_W-1:0] vr);
        t_vmap ent;
        int    victim;
        bit    owner_seen;
        cmd_words.delete();
        if (op <= OP_LDST) begin
            if (int'(vr) >= NUM_VIRT - 1) begin
                cmd_words.push_back(mk(K_BADREG, 0, 0));
            end else begin
                ent = virt_entry[vr];
                if (ent.valid) begin
                    // hit: re-mark in use, store flavors make it dirty
                    if (int'(ent.phys) < NUM_PHYS)
                        phys_mark[ent.phys] = MARK_INUSE;
                    if (op != OP_LOAD)
                        virt_entry[vr].dirty = 1'b1;
                    cmd_words.push_back(mk(K_GRANT, int'(ent.phys), int'(vr)));
                end else begin
                    // miss: lowest free register first
                    victim = -1;
                    for (int p = 0; p < NUM_PHYS; p++)
                        if (victim < 0 && phys_mark[p] == MARK_FREE)
                            victim = p;
                    // else evict the lowest mapped one, writing back a dirty owner
                    if (victim < 0) begin
                        for (int p = 0; p < NUM_PHYS; p++) begin
                            if (victim < 0 && phys_mark[p] == MARK_MAPPED) begin
                                victim = p;
                                owner_seen = 1'b0;
                                for (int v = 0; v < NUM_VIRT; v++) begin
                                    if (!owner_seen && virt_entry[v].valid &&
                                        int'(virt_entry[v].phys) == p) begin
                                        owner_seen = 1'b1;
                                        if (virt_entry[v].dirty)
                                            cmd_words.push_back(mk(K_WB, p, v));
                                        virt_entry[v] = '0;
                                    end
                                end
                            end
                        end
                    end
                    if (victim < 0) begin
                        cmd_words.push_back(mk(K_NOFREE, 0, 0));
                    end else begin
                        phys_mark[victim] = MARK_INUSE;
                        table_live = 1'b1;
                        if (op != OP_STORE)
                            cmd_words.push_back(mk(K_FILL, victim, int'(vr)));
                        virt_entry[vr].valid = 1'b1;
                        virt_entry[vr].dirty = (op != OP_LOAD);
                        virt_entry[vr].phys  = REG_W'(victim);
                        cmd_words.push_back(mk(K_GRANT, victim, int'(vr)));
                    end
                end
            end
        end else if (op == OP_FLUSH) begin
            // write back dirty entries in virtual order, then clear everything
            if (table_live) begin
                for (int v = 0; v < NUM_VIRT; v++) begin
                    if (virt_entry[v].valid && virt_entry[v].dirty && cmd_words.size() < NUM_PHYS)
                        cmd_words.push_back(mk(K_WB, int'(virt_entry[v].phys), v));
                    virt_entry[v] = '0;
                end
                for (int p = 0; p < NUM_PHYS; p++)
                    phys_mark[p] = MARK_FREE;
                table_live = 1'b0;
            end
            cmd_words.push_back(mk(K_DONE, 0, 0));
        end else if (op == OP_RELEASE) begin
            for (int p = 0; p < NUM_PHYS; p++)
                if (phys_mark[p] == MARK_INUSE)
                    phys_mark[p] = MARK_MAPPED;
            cmd_words.push_back(mk(K_DONE, 0, 0));
        end else begin
            cmd_words.push_back(mk(K_DONE, 0, 0));
        end
        cmd_words[cmd_words.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [REG_W-1:0] want,
                               input logic [REG_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checking and command capture both look at pre-edge values
    always @(posedge i_clk) begin : word_monitor
        t_word want;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with nothing outstanding: kind %0d phys %0d slot %0d",
                           o_kind, o_phys_reg, o_slot_reg);
                    fail_count++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("kind", REG_W'(want.kind), REG_W'(o_kind));
                    check_field("phys_reg", want.phys, o_phys_reg);
                    check_field("slot_reg", want.slot, o_slot_reg);
                    check_field("last", REG_W'(want.last), REG_W'(o_last));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                // shadow state always advances, even when the answer is typed in
                predict_command(i_opcode, i_virt_reg);
                if (typed_cnt > 0) begin
                    cmd_words.delete();
                    cmd_words.push_back(typed_first);
                    if (typed_cnt > 1)
                        cmd_words.push_back(typed_second);
                    cmd_words[cmd_words.size() - 1].last = 1'b1;
                end
                foreach (cmd_words[i])
                    awaited_words.push_back(cmd_words[i]);
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_row(input logic [OP_W-1:0] op, input logic [REG_W-1:0] vreg,
                           input int n, input t_word a, input t_word b);
        t_step_row r;
        r.op = op;
        r.vreg = vreg;
        r.typed_cnt = n;
        r.first = a;
        r.second = b;
        script.push_back(r);
    endtask

    // present one command word and hold it until the block takes it
    task automatic issue(input t_step_row r);
        start        <= 1'b1;
        i_opcode     <= r.op;
        i_virt_reg   <= r.vreg;
        typed_cnt    <= r.typed_cnt;
        typed_first  <= r.first;
        typed_second <= r.second;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_step_row r;
        int        release_pct;
        int        pick;
        bit        no_gaps;

        for (int v = 0; v < NUM_VIRT; v++)
            virt_entry[v] = '0;
        for (int p = 0; p < NUM_PHYS; p++)
            phys_mark[p] = MARK_FREE;
        table_live = 1'b0;

        // empty table: flush, release and undefined opcodes just say done
        add_row(OP_FLUSH,   4'd0,  1, mk(K_DONE, 0, 0), NO_WORD);
        add_row(OP_RELEASE, 4'd15, 1, mk(K_DONE, 0, 0), NO_WORD);
        add_row(OP_RSVD_A,  4'd15, 1, mk(K_DONE, 0, 0), NO_WORD);
        add_row(OP_RSVD_C,  4'd0,  1, mk(K_DONE, 0, 0), NO_WORD);
        // refused register on every access flavor
        add_row(OP_LOAD,  VREG_REFUSED, 1, mk(K_BADREG, 0, 0), NO_WORD);
        add_row(OP_STORE, VREG_REFUSED, 1, mk(K_BADREG, 0, 0), NO_WORD);
        add_row(OP_LDST,  VREG_REFUSED, 1, mk(K_BADREG, 0, 0), NO_WORD);
        // first misses take the lowest free registers; store gets no fill
        add_row(OP_LOAD,  4'd0,  2, mk(K_FILL, 0, 0), mk(K_GRANT, 0, 0));
        add_row(OP_STORE, 4'd14, 1, mk(K_GRANT, 1, 14), NO_WORD);
        add_row(OP_LDST,  4'd1,  2, mk(K_FILL, 2, 1), mk(K_GRANT, 2, 1));
        add_row(OP_LOAD,  4'd0,  1, mk(K_GRANT, 0, 0), NO_WORD);
        // fill the remaining registers, all left in use
        for (int v = 2; v <= 8; v++)
            add_row(OP_LOAD, REG_W'(v), 0, NO_WORD, NO_WORD);
        add_row(OP_LOAD,    4'd9, 1, mk(K_NOFREE, 0, 0), NO_WORD);
        add_row(OP_RELEASE, 4'd0, 1, mk(K_DONE, 0, 0), NO_WORD);
        add_row(OP_STORE,   4'd0, 1, mk(K_GRANT, 0, 0), NO_WORD);
        // evictions of dirty owners, then a flush with writebacks
        add_row(OP_LOAD,   4'd9,  0, NO_WORD, NO_WORD);
        add_row(OP_LDST,   4'd10, 0, NO_WORD, NO_WORD);
        add_row(OP_FLUSH,  4'd0,  0, NO_WORD, NO_WORD);
        add_row(OP_RSVD_B, 4'd7,  1, mk(K_DONE, 0, 0), NO_WORD);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            issue(script[i]);
            pause($urandom_range(0, 3));
        end

        // random part in bursts; each burst picks its own release rate and gap habit
        for (int b = 0; b < RAND_ITEMS / BURST; b++) begin
            case ($urandom_range(0, 2))
                0: release_pct = 2;
                1: release_pct = 10;
                default: release_pct = 30;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BURST; k++) begin
                pick = $urandom_range(0, 99);
                r.typed_cnt = 0;
                r.first = NO_WORD;
                r.second = NO_WORD;
                r.vreg = REG_W'($urandom());
                if (pick < release_pct) begin
                    r.op = OP_RELEASE;
                end else if (pick < release_pct + 3) begin
                    r.op = OP_FLUSH;
                end else if (pick < release_pct + 5) begin
                    r.op = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
                end else begin
                    r.op = OP_W'($urandom_range(OP_LOAD, OP_LDST));
                    if ($urandom_range(0, 24) == 0)
                        r.vreg = VREG_REFUSED;
                    else
                        r.vreg = REG_W'($urandom_range(0, NUM_VIRT - 2));
                end
                issue(r);
                pause(no_gaps ? 0 : $urandom_range(0, 3));
            end
        end
        start <= 1'b0;

        // drain: everything owed must arrive, then watch for strays
        do @(posedge i_clk); while (awaited_words.size() != 0);
        repeat (DRAIN) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
